FILE: hw/rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the scene text lexer
// The package holds the word formats of both channels, the plan word that
// passes from the front to the back, and the character constants.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] TOKEN_LIMIT = 10'd512;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_APOS    = 8'h27;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_EOF  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       at_eof;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tok_char;
    logic       last;
  } result_t;

  // One result slot of a plan.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } slot_t;

  // All results caused by one input word; n is between one and three.
  typedef struct packed {
    logic [1:0]      n;
    slot_t [2:0]     slot;
  } plan_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == 8'h3B) || (c == 8'h3D) || (c == 8'h5B) || (c == 8'h5D) ||
           (c == 8'h7B) || (c == 8'h7D) || (c == 8'h3C) || (c == 8'h3E) ||
           (c == 8'h5E) || (c == 8'h3A);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
  endfunction

endpackage

FILE: hw/rtl/scene_text_lexer.sv
// ----------------------------------------------------------------------------
// scene_text_lexer: byte-serial lexer for scene description text
// Takes one text byte per word and gives token characters, end-of-token
// marks and the end-of-file token.
// ----------------------------------------------------------------------------
// A word's plan is pushed into the plan queue, and the result sequencer moves
// its results from there into the output register.
// Throughput: one input word per cycle while the plan queue is not full; the
// result sequencer gives one result per cycle unless the output stalls, so a
// word with two or three results holds it longer and the four-entry plan queue absorbs the difference.
// Reset: mode normal, token count zero, plan queue and output register empty.
module scene_text_lexer (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  stl_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output stl_pkg::result_t result
);
  import stl_pkg::*;

  logic  accept;
  logic  push;
  logic  pop;
  logic  q_empty;
  logic  q_full;
  plan_t plan;
  plan_t head;

  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;

  stl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .push   (push),
    .plan   (plan)
  );

  stl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_plan (plan),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  stl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("plan pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !pop)
    else $error("plan popped from an empty queue");

  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.kind == KIND_EOF)) |-> result.last)
    else $error("end-of-file token not marked last");

  a_marks_carry_no_char: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.kind != KIND_CHAR)) |-> (result.tok_char == 8'h00))
    else $error("end mark carries a character");

  a_reset_clears_output: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

FILE: hw/rtl/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front: classifier of the scene text lexer
// Holds the lexer mode and the character count of the pending token, and
// turns each accepted input word into a plan of up to three results.
// ----------------------------------------------------------------------------
module stl_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  stl_pkg::item_t item,
  output logic           push,
  output stl_pkg::plan_t plan
);
  import stl_pkg::*;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'b001,
    MODE_COMMENT = 3'b010,
    MODE_STRING  = 3'b100
  } mode_t;

  mode_t            mode, mode_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] count_inc;
  logic             pending;
  logic             hit;
  logic             do_emit;
  logic [7:0]       emit_ch;
  logic [7:0]       c;

  assign c         = item.char_code;
  assign count_inc = count + CNT_W'(1);
  assign hit       = count_inc >= TOKEN_LIMIT;
  assign pending   = count != '0;

  always_comb begin
    plan       = '0;
    mode_next  = mode;
    count_next = count;
    do_emit    = 1'b0;
    emit_ch    = c;
    priority if (item.at_eof) begin
      mode_next  = MODE_NORMAL;
      count_next = '0;
      if (pending) begin
        plan.slot[0] = '{kind: KIND_END, ch: 8'h00};
        plan.slot[1] = '{kind: KIND_EOF, ch: 8'h00};
        plan.n       = 2'd2;
      end else begin
        plan.slot[0] = '{kind: KIND_EOF, ch: 8'h00};
        plan.n       = 2'd1;
      end
    end else if (c == CH_NUL) begin
      // NUL bytes are dropped in every mode.
    end else if (mode == MODE_COMMENT) begin
      if (c == CH_NEWLINE) begin
        mode_next = MODE_NORMAL;
        if (pending) begin
          plan.slot[0] = '{kind: KIND_END, ch: 8'h00};
          plan.n       = 2'd1;
          count_next   = '0;
        end
      end
    end else if (mode == MODE_STRING) begin
      if (c == CH_QUOTE) begin
        plan.slot[0] = '{kind: KIND_END, ch: 8'h00};
        plan.n       = 2'd1;
        count_next   = '0;
        mode_next    = MODE_NORMAL;
      end else begin
        do_emit = 1'b1;
      end
    end else if (is_blank(c)) begin
      if (pending) begin
        plan.slot[0] = '{kind: KIND_END, ch: 8'h00};
        plan.n       = 2'd1;
        count_next   = '0;
      end
    end else if (c == CH_HASH) begin
      mode_next = MODE_COMMENT;
    end else if (c == CH_QUOTE) begin
      mode_next = MODE_STRING;
      do_emit   = 1'b1;
      emit_ch   = CH_APOS;
    end else if (is_delim(c)) begin
      // A pending token is closed first, then the delimiter is its own token.
      count_next = '0;
      mode_next  = MODE_NORMAL;
      if (pending) begin
        plan.slot[0] = '{kind: KIND_END, ch: 8'h00};
        plan.slot[1] = '{kind: KIND_CHAR, ch: c};
        plan.slot[2] = '{kind: KIND_END, ch: 8'h00};
        plan.n       = 2'd3;
      end else begin
        plan.slot[0] = '{kind: KIND_CHAR, ch: c};
        plan.slot[1] = '{kind: KIND_END, ch: 8'h00};
        plan.n       = 2'd2;
      end
    end else begin
      do_emit = 1'b1;
    end

    // A character that fills the token to the limit closes it at once.
    if (do_emit) begin
      plan.slot[0] = '{kind: KIND_CHAR, ch: emit_ch};
      if (hit) begin
        plan.slot[1] = '{kind: KIND_END, ch: 8'h00};
        plan.n       = 2'd2;
        count_next   = '0;
        mode_next    = MODE_NORMAL;
      end else begin
        plan.n     = 2'd1;
        count_next = count_inc;
      end
    end
  end

  assign push = accept && (plan.n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_NORMAL;
      count <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      count <= count_next;
    end
  end

endmodule

FILE: hw/rtl/stl_queue.sv
// ----------------------------------------------------------------------------
// stl_queue: plan queue of the scene text lexer
// A short first-in first-out queue of plans that decouples the classifier
// from the result sequencer.
// ----------------------------------------------------------------------------
module stl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  stl_pkg::plan_t push_plan,
  input  logic           pop,
  output stl_pkg::plan_t head,
  output logic           empty,
  output logic           full
);
  import stl_pkg::*;

  plan_t             entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign head  = entry[rd_ptr];
  assign empty = fill == '0;
  assign full  = fill == QCNT_W'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: hw/rtl/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back: result sequencer of the scene text lexer
// Walks the slots of the plan at the head of the queue, one result word per
// cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module stl_back (
  input  logic             clk,
  input  logic             rst,
  input  stl_pkg::plan_t   head,
  input  logic             empty,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output stl_pkg::result_t result
);
  import stl_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       last;
  slot_t      cur;

  always_comb begin
    unique case (idx)
      2'd0:    cur = head.slot[0];
      2'd1:    cur = head.slot[1];
      default: cur = head.slot[2];
    endcase
  end

  assign last = idx == (head.n - 2'd1);
  assign load = !result_valid || !result_stall;
  assign pop  = load && !empty && last;

  always_ff @(posedge clk) begin
    if (load) begin
      result.kind     <= cur.kind;
      result.tok_char <= cur.ch;
      result.last     <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      result_valid <= !empty;
      if (!empty) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule
